// ===== hdl/soc_pkg.sv =====
`timescale 1ns / 1ps
package soc_pkg;
    localparam logic [1:0] REASON_NONE  = 2'd0;
    localparam logic [1:0] REASON_CLOSE = 2'd1;
    localparam logic [1:0] REASON_CROSS = 2'd2;

    localparam logic CFG_RADIUS = 1'b0;
    localparam logic CFG_FACTOR = 1'b1;

    // datapath operation selects
    typedef enum logic [1:0] {
        OP_EDGE_PREV  = 2'd0,
        OP_VERTEX     = 2'd1,
        OP_EDGE_CLOSE = 2'd2
    } soc_op_t;

    typedef struct packed {
        logic    load;     // capture input request
        logic    run;      // evaluate one test
        soc_op_t op;
    } soc_cmd_t;

    typedef struct packed {
        logic hit;         // selected test failed (valid while done is high)
        logic done;        // one-cycle pulse when the test result is ready
    } soc_sts_t;
endpackage

// ===== hdl/soc_datapath.sv =====
`timescale 1ns / 1ps
module soc_datapath
    import soc_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [15:0]                  radius,
    input  logic [11:0]                  factor,
    input  logic signed [COORD_BITS-1:0] seg_start_x,
    input  logic signed [COORD_BITS-1:0] seg_start_y,
    input  logic signed [COORD_BITS-1:0] seg_end_x,
    input  logic signed [COORD_BITS-1:0] seg_end_y,
    input  logic signed [COORD_BITS-1:0] vertex_x,
    input  logic signed [COORD_BITS-1:0] vertex_y,
    input  logic                         first_load,
    input  soc_cmd_t                     cmd,
    output soc_sts_t                     sts
);
    localparam int DW = COORD_BITS + 1;      // difference width
    localparam int SW = 2 * DW + 1;          // sum of two products
    localparam int MW = SW - 1;              // magnitude of such a sum
    localparam int QW = 2 * MW;              // square of a magnitude
    localparam int TW = 28;                  // radius times factor
    localparam int RW = TW + MW;             // partial clearance product
    localparam int CW = QW + 2 * TW + 1;     // final compare width

    logic signed [COORD_BITS-1:0] sx_reg, sy_reg, ex_reg, ey_reg, vx_reg, vy_reg;
    logic signed [COORD_BITS-1:0] px_reg, py_reg, fx_reg, fy_reg;
    logic signed [COORD_BITS-1:0] cx, cy, qx, qy;
    logic signed [DW-1:0] dx, dy, ux, uy, wx, wy;
    logic signed [SW-1:0] l2, dot, crs, pp, ee;
    logic signed [SW-1:0] o1, o2, o3, o4;
    logic signed [SW-1:0] l2_reg, dot_reg, crs_reg, pp_reg, ee_reg;
    logic [TW-1:0] t_reg;
    logic [MW-1:0] cmag, d2_reg, l2m_reg;
    logic [QW-1:0] csq_reg;
    logic [2*TW-1:0] t2_reg;
    logic [RW-1:0] rlo_reg, rhi_reg;
    logic [CW-1:0] lhs, rhs;
    logic near, far, mid_reg;
    logic run_e, run_v;
    logic v1_reg, v2_reg, v3_reg, done_reg;
    logic close_hit, cross_hit;
    logic hit_reg;

    assign run_e = cmd.run && (cmd.op != OP_VERTEX);
    assign run_v = cmd.run && (cmd.op == OP_VERTEX);

    // capture the request and keep the previous and first vertices
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sx_reg <= seg_start_x; sy_reg <= seg_start_y;
            ex_reg <= seg_end_x;   ey_reg <= seg_end_y;
            vx_reg <= vertex_x;    vy_reg <= vertex_y;
            px_reg <= vx_reg;      py_reg <= vy_reg;
            if (first_load) begin
                fx_reg <= vertex_x; fy_reg <= vertex_y;
            end
        end
    end

    function automatic logic signed [SW-1:0] orient(
        input logic signed [COORD_BITS-1:0] ax, ay, bx, by, kx, ky);
        logic signed [DW-1:0] a, b, c, d;
        begin
            a = DW'(bx) - DW'(ax); b = DW'(ky) - DW'(ay);
            c = DW'(by) - DW'(ay); d = DW'(kx) - DW'(ax);
            orient = SW'(a) * SW'(b) - SW'(c) * SW'(d);
        end
    endfunction

    // edge endpoints for the selected test
    always_comb begin
        cx = px_reg; cy = py_reg; qx = vx_reg; qy = vy_reg;
        if (cmd.op == OP_EDGE_CLOSE) begin
            cx = vx_reg; cy = vy_reg; qx = fx_reg; qy = fy_reg;
        end
    end

    always_comb begin
        o1 = orient(sx_reg, sy_reg, ex_reg, ey_reg, cx, cy);
        o2 = orient(sx_reg, sy_reg, ex_reg, ey_reg, qx, qy);
        o3 = orient(cx, cy, qx, qy, sx_reg, sy_reg);
        o4 = orient(cx, cy, qx, qy, ex_reg, ey_reg);
        cross_hit = (o1 != 0) && (o2 != 0) && (o3 != 0) && (o4 != 0)
                 && (o1[SW-1] != o2[SW-1]) && (o3[SW-1] != o4[SW-1]);
    end

    // clearance terms: segment length, projection, cross product, end distances
    always_comb begin
        dx = DW'(ex_reg) - DW'(sx_reg); dy = DW'(ey_reg) - DW'(sy_reg);
        ux = DW'(vx_reg) - DW'(sx_reg); uy = DW'(vy_reg) - DW'(sy_reg);
        wx = DW'(vx_reg) - DW'(ex_reg); wy = DW'(vy_reg) - DW'(ey_reg);
        l2  = SW'(dx) * SW'(dx) + SW'(dy) * SW'(dy);
        dot = SW'(ux) * SW'(dx) + SW'(uy) * SW'(dy);
        crs = SW'(ux) * SW'(dy) - SW'(uy) * SW'(dx);
        pp  = SW'(ux) * SW'(ux) + SW'(uy) * SW'(uy);
        ee  = SW'(wx) * SW'(wx) + SW'(wy) * SW'(wy);
    end

    // stage 2 selects: point distance near either end, else line distance
    always_comb begin
        near = (l2_reg == 0) || (dot_reg <= 0);
        far  = (dot_reg >= l2_reg);
        cmag = crs_reg[SW-1] ? MW'(-crs_reg) : MW'(crs_reg);
    end

    // stage 4 compare, squared distances cross-multiplied
    always_comb begin
        if (mid_reg) begin
            lhs = CW'(csq_reg) << 16;
            rhs = (CW'(rhi_reg) << TW) + CW'(rlo_reg);
        end else begin
            lhs = CW'(d2_reg) << 16;
            rhs = CW'(t2_reg);
        end
        close_hit = lhs < rhs;
    end

    // clearance pipeline, one test in flight at a time
    always_ff @(posedge aclk) begin
        if (run_v) begin
            l2_reg <= l2; dot_reg <= dot; crs_reg <= crs;
            pp_reg <= pp; ee_reg <= ee;
            t_reg  <= TW'(radius) * TW'(factor);
        end
        if (v1_reg) begin
            mid_reg <= !near && !far;
            d2_reg  <= near ? MW'(pp_reg) : MW'(ee_reg);
            l2m_reg <= MW'(l2_reg);
            csq_reg <= QW'(cmag) * QW'(cmag);
            t2_reg  <= (2*TW)'(t_reg) * (2*TW)'(t_reg);
        end
        if (v2_reg) begin
            rlo_reg <= RW'(t2_reg[TW-1:0]) * RW'(l2m_reg);
            rhi_reg <= RW'(t2_reg[2*TW-1:TW]) * RW'(l2m_reg);
        end
    end

    // advance the stage flags and register the selected result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0;
            done_reg <= 1'b0; hit_reg <= 1'b0;
        end else begin
            v1_reg <= run_v; v2_reg <= v1_reg; v3_reg <= v2_reg;
            done_reg <= run_e || v3_reg;
            if (run_e) begin
                hit_reg <= cross_hit;
            end else if (v3_reg) begin
                hit_reg <= close_hit;
            end
        end
    end

    assign sts.hit  = hit_reg;
    assign sts.done = done_reg;
endmodule

// ===== hdl/soc_ctrl.sv =====
`timescale 1ns / 1ps
module soc_ctrl
    import soc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       polygon_last,
    input  logic       query_last,
    output logic       first_load,
    output soc_cmd_t   cmd,
    input  soc_sts_t   sts,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_path_clear,
    output logic [1:0] m_block_reason
);
    typedef enum logic [2:0] {
        S_IDLE, S_EDGE, S_VERT, S_VWAIT, S_CLOSE, S_CHECK
    } state_t;

    state_t state_reg, state_next;
    logic inside_reg, inside_next;
    logic plast_reg, plast_next, qlast_reg, qlast_next;
    logic [1:0] fail_reg, fail_next, last_op_reg, last_op_next;
    logic m_valid_reg, m_valid_next, clear_reg, clear_next;
    logic [1:0] reason_reg, reason_next;
    logic accept;

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign first_load = accept && !inside_reg;
    assign m_valid = m_valid_reg;
    assign m_path_clear = clear_reg;
    assign m_block_reason = reason_reg;

    always_comb begin
        state_next = state_reg; inside_next = inside_reg;
        plast_next = plast_reg; qlast_next = qlast_reg; fail_next = fail_reg;
        last_op_next = last_op_reg; m_valid_next = m_valid_reg;
        clear_next = clear_reg; reason_next = reason_reg;
        cmd = '{load: accept, run: 1'b0, op: OP_VERTEX};
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        // fold the finished test into the failure code
        if (sts.done && fail_reg == REASON_NONE && sts.hit) begin
            fail_next = (last_op_reg == 2'(OP_VERTEX)) ? REASON_CLOSE : REASON_CROSS;
        end
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    plast_next = polygon_last || query_last;
                    qlast_next = query_last;
                    state_next = inside_reg ? S_EDGE : S_VERT;
                    inside_next = 1'b1;
                end
            end
            S_EDGE: begin
                cmd.run = 1'b1; cmd.op = OP_EDGE_PREV;
                last_op_next = 2'(OP_EDGE_PREV);
                state_next = S_VERT;
            end
            S_VERT: begin
                cmd.run = 1'b1; cmd.op = OP_VERTEX;
                last_op_next = 2'(OP_VERTEX);
                state_next = S_VWAIT;
            end
            S_VWAIT: begin
                // hold until the clearance pipeline drains
                if (sts.done) begin
                    state_next = plast_reg ? S_CLOSE : S_CHECK;
                end
            end
            S_CLOSE: begin
                cmd.run = 1'b1; cmd.op = OP_EDGE_CLOSE;
                last_op_next = 2'(OP_EDGE_CLOSE);
                inside_next = 1'b0;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                // on the last request of a query, issue the verdict once the output register is free
                if (!qlast_reg) begin
                    state_next = S_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    clear_next = (fail_next == REASON_NONE);
                    reason_next = fail_next;
                    fail_next = REASON_NONE;
                    state_next = S_IDLE;
                end else begin
                    qlast_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; inside_reg <= 1'b0;
            plast_reg <= 1'b0; qlast_reg <= 1'b0; fail_reg <= REASON_NONE;
            last_op_reg <= 2'(OP_VERTEX); m_valid_reg <= 1'b0;
            clear_reg <= 1'b0; reason_reg <= REASON_NONE;
        end else begin
            state_reg <= state_next; inside_reg <= inside_next;
            plast_reg <= plast_next; qlast_reg <= qlast_next; fail_reg <= fail_next;
            last_op_reg <= last_op_next; m_valid_reg <= m_valid_next;
            clear_reg <= clear_next; reason_reg <= reason_next;
        end
    end
endmodule

// ===== hdl/segment_obstacle_clearance_top.sv =====
`timescale 1ns / 1ps
// Segment/polygon clearance check. Each request carries the candidate segment
// and one obstacle vertex; one verdict (path_clear, block_reason) is issued on
// the request that has query_last set. A request occupies the block from one
// accept to the next: the accepting idle state, an edge test against the
// previous vertex when a polygon is open, the vertex clearance test (issue plus
// a four-stage multiply pipeline, waited out in S_VWAIT), the closing edge on
// polygon or query end, and a check state that folds the last test and issues
// the verdict. A verdict waits in that check state while an earlier one still
// sits unaccepted in the output register. Config writes: index 0 robot radius,
// 1 safety factor; write them only while no request is in work.
module segment_obstacle_clearance_top
    import soc_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [15:0]                  cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_seg_start_x,
    input  logic signed [COORD_BITS-1:0] s_seg_start_y,
    input  logic signed [COORD_BITS-1:0] s_seg_end_x,
    input  logic signed [COORD_BITS-1:0] s_seg_end_y,
    input  logic signed [COORD_BITS-1:0] s_vertex_x,
    input  logic signed [COORD_BITS-1:0] s_vertex_y,
    input  logic                         s_polygon_last,
    input  logic                         s_query_last,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_path_clear,
    output logic [1:0]                   m_block_reason
);
    logic [15:0] radius_reg;
    logic [11:0] factor_reg;
    logic first_load;
    soc_cmd_t cmd;
    soc_sts_t sts;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= '0;
            factor_reg <= 12'd256;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_RADIUS: radius_reg <= cfg_wdata;
                CFG_FACTOR: factor_reg <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    soc_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready,
        .polygon_last(s_polygon_last), .query_last(s_query_last),
        .first_load, .cmd, .sts, .m_valid, .m_ready,
        .m_path_clear, .m_block_reason
    );

    soc_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
        .aclk, .aresetn, .radius(radius_reg), .factor(factor_reg),
        .seg_start_x(s_seg_start_x), .seg_start_y(s_seg_start_y),
        .seg_end_x(s_seg_end_x), .seg_end_y(s_seg_end_y),
        .vertex_x(s_vertex_x), .vertex_y(s_vertex_y),
        .first_load, .cmd, .sts
    );
endmodule

// ===== hdl/soc_checker.sv =====
`timescale 1ns / 1ps
module soc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_path_clear,
    input logic [1:0] m_block_reason
);
    // verdict is consistent with its reason
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_path_clear == (m_block_reason == 2'd0))) else $error("clear");
    a_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_block_reason != 2'd3)) else $error("reason");
    // one request in work at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("busy");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_block_reason)) else $error("hold");
endmodule

bind segment_obstacle_clearance_top soc_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
    .m_path_clear, .m_block_reason
);

// ===== tb/tb_segment_obstacle_clearance_top.sv =====
`timescale 1ns / 1ps
module tb_segment_obstacle_clearance_top;
    import soc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 12;

    typedef struct {
        logic signed [15:0] sx, sy, ex, ey, vx, vy;
        logic               pl, ql;
    } seg_req_t;

    typedef struct {
        logic       clear;
        logic [1:0] reason;
    } verdict_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = CFG_RADIUS;
    logic [15:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_seg_start_x = '0, s_seg_start_y = '0;
    logic signed [15:0] s_seg_end_x = '0, s_seg_end_y = '0;
    logic signed [15:0] s_vertex_x = '0, s_vertex_y = '0;
    logic s_polygon_last = 1'b0, s_query_last = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_path_clear;
    logic [1:0] m_block_reason;

    seg_req_t pending_reqs[$];
    verdict_t expected_verdicts[$];
    int       mismatches = 0;
    int       idle_cycles = 0;

    // clearance registers and geometry state of the predictor
    logic [15:0] radius_q = 16'd0;
    logic [11:0] factor_q = 12'd256;
    longint      first_x, first_y, prev_x, prev_y;
    bit          poly_open;
    logic [1:0]  fail_q;

    always #2 aclk = ~aclk;

    segment_obstacle_clearance_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_seg_start_x(s_seg_start_x), .s_seg_start_y(s_seg_start_y),
        .s_seg_end_x(s_seg_end_x), .s_seg_end_y(s_seg_end_y),
        .s_vertex_x(s_vertex_x), .s_vertex_y(s_vertex_y),
        .s_polygon_last(s_polygon_last), .s_query_last(s_query_last),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_path_clear(m_path_clear), .m_block_reason(m_block_reason)
    );

    // sign of (b-a) x (c-a), exact in 64 bits for 17-bit differences
    function automatic int orientation(longint ax, ay, bx, by, cx, cy);
        longint v;
        v = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic bit edge_crosses(longint ax, ay, bx, by, cx, cy, dx, dy);
        int o1, o2, o3, o4;
        o1 = orientation(ax, ay, bx, by, cx, cy);
        o2 = orientation(ax, ay, bx, by, dx, dy);
        o3 = orientation(cx, cy, dx, dy, ax, ay);
        o4 = orientation(cx, cy, dx, dy, bx, by);
        if (o1 == 0 || o2 == 0 || o3 == 0 || o4 == 0)
            return 1'b0;
        return (o1 != o2) && (o3 != o4);
    endfunction

    function automatic bit vertex_too_close(longint sx, sy, ex, ey, vx, vy);
        longint dx, dy, px, py, l2, dot, c;
        logic [127:0] thr, thr2, dist2, cmag, len2;
        dx = ex - sx; dy = ey - sy;
        px = vx - sx; py = vy - sy;
        thr = 128'(radius_q) * 128'(factor_q);
        thr2 = thr * thr;
        l2 = dx * dx + dy * dy;
        dot = px * dx + py * dy;
        if (l2 == 0 || dot <= 0) begin
            dist2 = 128'(px * px + py * py);
        end else if (dot >= l2) begin
            dist2 = 128'((vx - ex) * (vx - ex) + (vy - ey) * (vy - ey));
        end else begin
            c = px * dy - py * dx;
            if (c < 0) c = -c;
            cmag = 128'(c);
            len2 = 128'(l2);
            return ((cmag * cmag) << 16) < thr2 * len2;
        end
        return (dist2 << 16) < thr2;
    endfunction

    // advance the geometry state by one accepted request
    function automatic void fold_request(seg_req_t r);
        longint sx, sy, ex, ey, vx, vy;
        verdict_t v;
        sx = r.sx; sy = r.sy; ex = r.ex; ey = r.ey; vx = r.vx; vy = r.vy;
        if (!poly_open) begin
            first_x = vx; first_y = vy; poly_open = 1'b1;
        end else if (fail_q == REASON_NONE &&
                     edge_crosses(sx, sy, ex, ey, prev_x, prev_y, vx, vy)) begin
            fail_q = REASON_CROSS;
        end
        if (fail_q == REASON_NONE && vertex_too_close(sx, sy, ex, ey, vx, vy))
            fail_q = REASON_CLOSE;
        prev_x = vx; prev_y = vy;
        if (r.pl || r.ql) begin
            if (fail_q == REASON_NONE &&
                edge_crosses(sx, sy, ex, ey, vx, vy, first_x, first_y))
                fail_q = REASON_CROSS;
            poly_open = 1'b0;
        end
        if (r.ql) begin
            v.clear = (fail_q == REASON_NONE);
            v.reason = fail_q;
            expected_verdicts.push_back(v);
            fail_q = REASON_NONE;
        end
    endfunction

    // driver: bursts of requests with random gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge aclk) begin
        seg_req_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                r.sx = s_seg_start_x; r.sy = s_seg_start_y;
                r.ex = s_seg_end_x; r.ey = s_seg_end_y;
                r.vx = s_vertex_x; r.vy = s_vertex_y;
                r.pl = s_polygon_last; r.ql = s_query_last;
                fold_request(r);
            end
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    r = pending_reqs.pop_front();
                    s_seg_start_x <= r.sx; s_seg_start_y <= r.sy;
                    s_seg_end_x <= r.ex; s_seg_end_y <= r.ey;
                    s_vertex_x <= r.vx; s_vertex_y <= r.vy;
                    s_polygon_last <= r.pl; s_query_last <= r.ql;
                    s_valid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare verdicts, stall on a changing pattern
    int stall_mode = 0, stall_count = 0;
    always @(posedge aclk) begin
        verdict_t v;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected verdict clear=%0d reason=%0d",
                                 m_path_clear, m_block_reason);
                end else begin
                    v = expected_verdicts.pop_front();
                    if (m_path_clear !== v.clear || m_block_reason !== v.reason) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("verdict mismatch: expected clear=%0d reason=%0d, got clear=%0d reason=%0d",
                                     v.clear, v.reason, m_path_clear, m_block_reason);
                    end
                end
            end
            if (stall_count == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_count = $urandom_range(16, 128);
            end else begin
                stall_count--;
            end
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // watchdog on handshake activity
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic signed [15:0] clamp16(int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return 16'(v);
    endfunction

    task automatic push_req(int sx, sy, ex, ey, vx, vy, bit pl, bit ql);
        seg_req_t r;
        r.sx = clamp16(sx); r.sy = clamp16(sy);
        r.ex = clamp16(ex); r.ey = clamp16(ey);
        r.vx = clamp16(vx); r.vy = clamp16(vy);
        r.pl = pl; r.ql = ql;
        pending_reqs.push_back(r);
    endtask

    function automatic int rnd_full();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int rnd_near(int c, int span);
        return c + int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // one query: polygons scattered around a random segment
    task automatic push_query();
        int sx, sy, ex, ey, cx, cy, span, npoly, nvert, fsx, fsy, fex, fey;
        bit full, drop_close;
        full = ($urandom_range(0, 9) == 0);
        if (full) begin
            sx = rnd_full(); sy = rnd_full(); ex = rnd_full(); ey = rnd_full();
        end else begin
            sx = rnd_near(0, 2048); sy = rnd_near(0, 2048);
            if ($urandom_range(0, 15) == 0) begin
                ex = sx; ey = sy;
            end else begin
                ex = rnd_near(sx, 1024); ey = rnd_near(sy, 1024);
            end
        end
        npoly = $urandom_range(1, 3);
        drop_close = ($urandom_range(0, 7) == 0);
        for (int p = 0; p < npoly; p++) begin
            nvert = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 5);
            span = full ? 32768 : $urandom_range(16, 768);
            cx = sx + (ex - sx) * int'($urandom_range(0, 4)) / 4;
            cy = sy + (ey - sy) * int'($urandom_range(0, 4)) / 4;
            cx = rnd_near(cx, 256); cy = rnd_near(cy, 256);
            for (int k = 0; k < nvert; k++) begin
                bit last_v, last_q;
                last_v = (k == nvert - 1);
                last_q = last_v && (p == npoly - 1);
                fsx = sx; fsy = sy; fex = ex; fey = ey;
                if ($urandom_range(0, 19) == 0) begin
                    fsx = rnd_near(sx, 64); fey = rnd_near(ey, 64);
                end
                push_req(fsx, fsy, fex, fey,
                         full ? rnd_full() : rnd_near(cx, span),
                         full ? rnd_full() : rnd_near(cy, span),
                         last_v && !(last_q && drop_close), last_q);
            end
        end
    endtask

    task automatic push_noise();
        push_req(rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full(),
                 $urandom_range(0, 1), ($urandom_range(0, 3) == 0));
    endtask

    task automatic fill_random(int n);
        int target;
        target = pending_reqs.size() + n;
        while (pending_reqs.size() < target) begin
            if ($urandom_range(0, 9) == 0) push_noise();
            else push_query();
        end
        // close whatever query noise left open
        push_req(0, 0, 256, 0, 5000, 5000, 1'b1, 1'b1);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_valid || expected_verdicts.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_clearance(logic [15:0] radius, logic [11:0] factor);
        @(posedge aclk);
        cfg_we <= 1'b1; cfg_index <= CFG_RADIUS; cfg_wdata <= radius;
        @(posedge aclk);
        cfg_index <= CFG_FACTOR; cfg_wdata <= 16'(factor);
        @(posedge aclk);
        cfg_we <= 1'b0;
        radius_q = radius;
        factor_q = factor;
    endtask

    logic [15:0] radius_set[7] = '{16'd256, 16'd0, 16'd65535, 16'd128, 16'd512, 16'd40, 16'd65535};
    logic [11:0] factor_set[7] = '{12'd256, 12'd0, 12'd4095, 12'd256, 12'd384, 12'd4095, 12'd0};

    initial begin
        poly_open = 1'b0;
        fail_q = REASON_NONE;
        first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset clearance is zero: crossings, touching and degenerate cases
        push_req(-512, 0, 512, 0, -256, -256, 0, 0);
        push_req(-512, 0, 512, 0, 256, -256, 0, 0);
        push_req(-512, 0, 512, 0, 256, 256, 0, 0);
        push_req(-512, 0, 512, 0, -256, 256, 1, 1);
        push_req(-512, 0, 512, 0, 0, 0, 0, 0);
        push_req(-512, 0, 512, 0, 100, 100, 0, 0);
        push_req(-512, 0, 512, 0, -100, 100, 1, 1);
        push_req(-512, 0, 512, 0, 0, 256, 1, 0);
        push_req(-512, 0, 512, 0, 0, -256, 1, 1);
        push_req(-512, 0, 512, 0, -100, -100, 0, 0);
        push_req(-512, 0, 512, 0, 100, -100, 0, 0);
        push_req(-512, 0, 512, 0, 0, 200, 0, 1);
        push_req(5, 5, 5, 5, -100, -100, 0, 0);
        push_req(5, 5, 5, 5, 100, -100, 0, 0);
        push_req(5, 5, 5, 5, 0, 100, 1, 1);
        push_req(-32768, -32768, 32767, 32767, 32767, -32768, 0, 0);
        push_req(-32768, -32768, 32767, 32767, -32768, 32767, 1, 1);
        push_req(32767, -32768, -32768, 32767, -32768, -32768, 1, 1);
        fill_random(150);
        wait_drained();

        foreach (radius_set[i]) begin
            write_clearance(radius_set[i], factor_set[i]);
            if (i == 0) begin
                // one metre clearance: near vertex, end cap, point segment
                push_req(0, 0, 1024, 0, 512, 100, 1, 1);
                push_req(0, 0, 1024, 0, 512, 2000, 1, 1);
                push_req(0, 0, 1024, 0, 1200, 0, 1, 1);
                push_req(0, 0, 0, 0, 200, 0, 1, 1);
                push_req(0, 0, 1024, 0, 512, 100, 0, 0);
                push_req(0, 0, 1024, 0, 512, -2000, 1, 1);
            end
            fill_random(180);
            wait_drained();
        end

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/soc_pkg.sv
hdl/soc_datapath.sv
hdl/soc_ctrl.sv
hdl/segment_obstacle_clearance_top.sv
hdl/soc_checker.sv
tb/tb_segment_obstacle_clearance_top.sv
